// File: rtl/assert_macros.svh
// Concurrent assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising clock edge outside reset
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expr must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

// File: rtl/sv39ptm_pkg.sv
`timescale 1ns / 1ps

package sv39ptm_pkg;

   localparam int PPN_W       = 44;
   localparam int VPAGE_W     = 27;
   localparam int PERM_W      = 10;
   localparam int COUNT_W     = 13;
   localparam int RADDR_W     = 15;
   localparam int ENTRY_W     = 64;
   localparam int TUSE_W      = 7;
   localparam int IDX_W       = 9;
   localparam int ENTRIES     = 1 << IDX_W;
   localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
   localparam int VPN1_LSB    = IDX_W;
   localparam int VPN2_LSB    = 2 * IDX_W;
   localparam int PTE_PPN_LSB = PERM_W;
   localparam int PTE_V_BIT   = 0;

   localparam logic OP_MAP  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_TABLE = 2'd1,
      STATUS_BAD_PTR  = 2'd2
   } status_type;

   typedef struct packed {
      logic                 op;
      logic [VPAGE_W-1:0]   virt_page;
      logic [PPN_W-1:0]     phys_page;
      logic [PERM_W-1:0]    perm_bits;
      logic [COUNT_W-1:0]   page_count;
      logic [RADDR_W-1:0]   read_address;
   } req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0]   read_data;
      logic [COUNT_W-1:0]   pages_mapped;
      logic [TUSE_W-1:0]    tables_in_use;
      status_type           status;
   } rsp_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic rd_root;
      logic rd_mid;
      logic rd_entry;
      logic resolve;
      logic write_leaf;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic op_read;
      logic count_zero;
      logic last_page;
      logic walk_fail;
   } flags_type;

endpackage

// File: rtl/sv39ptm_ram.sv
`timescale 1ns / 1ps

module sv39ptm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sv39ptm_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sv39ptm_dp #(
   parameter int TABLE_PAGES   = 64,
   parameter int MAX_RUN_PAGES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sv39ptm_pkg::cmd_type          cmd,
   output sv39ptm_pkg::flags_type        flags,
   input  sv39ptm_pkg::req_type          req_data,
   input  logic                          csr_valid,
   input  logic [sv39ptm_pkg::PPN_W-1:0] csr_data,
   output sv39ptm_pkg::rsp_type          rsp_data
);

   localparam int DEPTH  = TABLE_PAGES * sv39ptm_pkg::ENTRIES;
   localparam int SLOT_W = $clog2(TABLE_PAGES);
   localparam int CNT_W  = $clog2(TABLE_PAGES + 1);
   localparam int ADDR_W = SLOT_W + sv39ptm_pkg::IDX_W;
   localparam int UA_W   = ADDR_W + sv39ptm_pkg::RADDR_W;
   localparam int TU_W   = CNT_W + sv39ptm_pkg::TUSE_W;
   localparam int PPN_W  = sv39ptm_pkg::PPN_W;
   localparam int IDX_W  = sv39ptm_pkg::IDX_W;
   localparam logic [sv39ptm_pkg::COUNT_W-1:0] RUN_LIMIT =
      (MAX_RUN_PAGES > sv39ptm_pkg::COUNT_MAX) ?
      sv39ptm_pkg::COUNT_W'(sv39ptm_pkg::COUNT_MAX) : sv39ptm_pkg::COUNT_W'(MAX_RUN_PAGES);

   logic [PPN_W-1:0]                   base_ff;
   logic [CNT_W-1:0]                   nfs_ff;
   logic [ADDR_W-1:0]                  clr_ff;
   logic                               op_ff;
   logic [sv39ptm_pkg::VPAGE_W-1:0]    vp_ff;
   logic [PPN_W-1:0]                   pp_ff;
   logic [sv39ptm_pkg::PERM_W-1:0]     perm_ff;
   logic [sv39ptm_pkg::COUNT_W-1:0]    remaining_ff;
   logic [sv39ptm_pkg::COUNT_W-1:0]    mapped_ff;
   logic [sv39ptm_pkg::RADDR_W-1:0]    raddr_ff;
   logic [ADDR_W-1:0]                  rd_addr_ff;
   logic [SLOT_W-1:0]                  walk_slot_ff;
   logic [sv39ptm_pkg::ENTRY_W-1:0]    read_data_ff;
   sv39ptm_pkg::status_type            status_ff;

   logic [sv39ptm_pkg::COUNT_W-1:0]    count_clamped;
   logic                               ram_wr_en;
   logic [ADDR_W-1:0]                  ram_wr_addr;
   logic [sv39ptm_pkg::ENTRY_W-1:0]    ram_wr_data;
   logic                               ram_rd_en;
   logic [ADDR_W-1:0]                  ram_rd_addr;
   logic [sv39ptm_pkg::ENTRY_W-1:0]    ram_rd_data;
   logic                               entry_valid;
   logic [PPN_W-1:0]                   entry_ppn;
   logic [PPN_W-1:0]                   rel;
   logic                               rel_ok;
   logic                               alloc_ok;
   logic                               walk_fail;
   logic                               alloc_now;
   logic [SLOT_W-1:0]                  slot_in;
   logic [sv39ptm_pkg::ENTRY_W-1:0]    ptr_entry;
   logic [sv39ptm_pkg::ENTRY_W-1:0]    leaf_entry;
   logic [UA_W-1:0]                    user_wide;
   logic                               user_in_range;
   logic [TU_W-1:0]                    nfs_wide;

   sv39ptm_ram #(
      .WIDTH (sv39ptm_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign count_clamped = (req_data.page_count > RUN_LIMIT) ? RUN_LIMIT : req_data.page_count;

   assign entry_valid = ram_rd_data[sv39ptm_pkg::PTE_V_BIT];
   assign entry_ppn   = ram_rd_data[sv39ptm_pkg::PTE_PPN_LSB +: PPN_W];
   assign rel         = entry_ppn - base_ff;
   assign rel_ok      = rel < PPN_W'(TABLE_PAGES);
   assign alloc_ok    = nfs_ff < CNT_W'(TABLE_PAGES);
   assign walk_fail   = entry_valid ? !rel_ok : !alloc_ok;
   assign alloc_now   = cmd.resolve && !walk_fail && !entry_valid;
   assign slot_in     = entry_valid ? rel[SLOT_W-1:0] : nfs_ff[SLOT_W-1:0];

   assign ptr_entry  = {10'b0, base_ff + PPN_W'(nfs_ff), 9'b0, 1'b1};
   assign leaf_entry = {10'b0, pp_ff, perm_ff};

   assign user_wide     = UA_W'(raddr_ff);
   assign user_in_range = 32'(raddr_ff) < 32'(DEPTH);
   assign nfs_wide      = TU_W'(nfs_ff);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_ff;
      ram_wr_data = '0;
      if (cmd.clear_step) begin
         ram_wr_en = 1'b1;
      end else if (alloc_now) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = rd_addr_ff;
         ram_wr_data = ptr_entry;
      end else if (cmd.write_leaf) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = {walk_slot_ff, vp_ff[IDX_W-1:0]};
         ram_wr_data = leaf_entry;
      end
   end

   always_comb begin
      ram_rd_en   = cmd.rd_root || cmd.rd_mid || cmd.rd_entry;
      ram_rd_addr = {SLOT_W'(0), vp_ff[sv39ptm_pkg::VPN2_LSB +: IDX_W]};
      if (cmd.rd_mid) begin
         ram_rd_addr = {walk_slot_ff, vp_ff[sv39ptm_pkg::VPN1_LSB +: IDX_W]};
      end else if (cmd.rd_entry) begin
         ram_rd_addr = user_wide[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         nfs_ff  <= CNT_W'(1);
         clr_ff  <= '0;
      end else begin
         if (csr_valid) begin
            base_ff <= csr_data;
         end
         if (alloc_now) begin
            nfs_ff <= nfs_ff + CNT_W'(1);
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_data.op;
         vp_ff        <= req_data.virt_page;
         pp_ff        <= req_data.phys_page;
         perm_ff      <= req_data.perm_bits;
         remaining_ff <= count_clamped;
         raddr_ff     <= req_data.read_address;
         mapped_ff    <= '0;
         read_data_ff <= '0;
         status_ff    <= sv39ptm_pkg::STATUS_OK;
      end
      if (ram_rd_en) begin
         rd_addr_ff <= ram_rd_addr;
      end
      if (cmd.resolve) begin
         if (walk_fail) begin
            status_ff <= entry_valid ? sv39ptm_pkg::STATUS_BAD_PTR : sv39ptm_pkg::STATUS_NO_TABLE;
         end else begin
            walk_slot_ff <= slot_in;
         end
      end
      if (cmd.write_leaf) begin
         mapped_ff    <= mapped_ff + sv39ptm_pkg::COUNT_W'(1);
         remaining_ff <= remaining_ff - sv39ptm_pkg::COUNT_W'(1);
         vp_ff        <= vp_ff + sv39ptm_pkg::VPAGE_W'(1);
         pp_ff        <= pp_ff + PPN_W'(1);
      end
      if (cmd.capture) begin
         read_data_ff <= user_in_range ? ram_rd_data : '0;
         status_ff    <= user_in_range ? sv39ptm_pkg::STATUS_OK : sv39ptm_pkg::STATUS_BAD_PTR;
      end
   end

   always_comb begin
      flags.clear_done = clr_ff == ADDR_W'(DEPTH - 1);
      flags.op_read    = op_ff == sv39ptm_pkg::OP_READ;
      flags.count_zero = remaining_ff == '0;
      flags.last_page  = remaining_ff == sv39ptm_pkg::COUNT_W'(1);
      flags.walk_fail  = walk_fail;
   end

   always_comb begin
      rsp_data.read_data     = read_data_ff;
      rsp_data.pages_mapped  = mapped_ff;
      rsp_data.tables_in_use = nfs_wide[sv39ptm_pkg::TUSE_W-1:0];
      rsp_data.status        = status_ff;
   end

   `ASSERT_NEVER(a_leaf_without_pages, clock, reset, cmd.write_leaf && remaining_ff == '0)
   `ASSERT_AT(a_leaf_slot_in_store, clock, reset, cmd.write_leaf |-> 32'(walk_slot_ff) < TABLE_PAGES)

endmodule

// File: rtl/sv39ptm_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sv39ptm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   output sv39ptm_pkg::cmd_type   cmd,
   input  sv39ptm_pkg::flags_type flags
);

   typedef enum logic [3:0] {
      CLEAR_S,
      IDLE_S,
      DECODE_S,
      RD_ROOT_S,
      CHK_ROOT_S,
      RD_MID_S,
      CHK_MID_S,
      WR_LEAF_S,
      RD_ENTRY_S,
      CAP_ENTRY_S
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         CLEAR_S: begin
            cmd.clear_step = 1'b1;
            if (flags.clear_done) begin
               state_in = IDLE_S;
            end
         end
         IDLE_S: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = DECODE_S;
            end
         end
         DECODE_S: begin
            if (flags.op_read) begin
               state_in = RD_ENTRY_S;
            end else if (flags.count_zero) begin
               rsp_valid_in = 1'b1;
               state_in     = IDLE_S;
            end else begin
               state_in = RD_ROOT_S;
            end
         end
         RD_ROOT_S: begin
            cmd.rd_root = 1'b1;
            state_in    = CHK_ROOT_S;
         end
         CHK_ROOT_S: begin
            cmd.resolve = 1'b1;
            if (flags.walk_fail) begin
               rsp_valid_in = 1'b1;
               state_in     = IDLE_S;
            end else begin
               state_in = RD_MID_S;
            end
         end
         RD_MID_S: begin
            cmd.rd_mid = 1'b1;
            state_in   = CHK_MID_S;
         end
         CHK_MID_S: begin
            cmd.resolve = 1'b1;
            if (flags.walk_fail) begin
               rsp_valid_in = 1'b1;
               state_in     = IDLE_S;
            end else begin
               state_in = WR_LEAF_S;
            end
         end
         WR_LEAF_S: begin
            cmd.write_leaf = 1'b1;
            if (flags.last_page) begin
               rsp_valid_in = 1'b1;
               state_in     = IDLE_S;
            end else begin
               state_in = RD_ROOT_S;
            end
         end
         RD_ENTRY_S: begin
            cmd.rd_entry = 1'b1;
            state_in     = CAP_ENTRY_S;
         end
         CAP_ENTRY_S: begin
            cmd.capture  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = IDLE_S;
         end
         default: begin
            state_in = IDLE_S;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR_S;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = state_ff != IDLE_S;
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_AT(a_no_instant_response, clock, reset, (start && !busy) |=> !rsp_valid_ff)
   `ASSERT_AT(a_response_when_idle, clock, reset, rsp_valid_ff |-> !busy)

endmodule

// File: rtl/sv39_page_table_mapper.sv
`timescale 1ns / 1ps

// Sv39 page table mapper. After reset the block clears its table store of
// TABLE_PAGES * 512 entries (32768 at the default size), one entry per cycle,
// with busy high; csr writes are taken during that pass. A request is taken
// when start is high and busy is low. Every entry touch goes through the table
// RAM with a registered read, so each level of the walk is a read state
// followed by a check/write state. A map stops early on an error. The result
// appears on rsp_data for exactly one cycle with rsp_valid high and cannot be
// held off; the next request may be taken in that same cycle.

module sv39_page_table_mapper #(
   parameter int TABLE_PAGES   = 64,
   parameter int MAX_RUN_PAGES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  sv39ptm_pkg::req_type          req_data,
   output logic                          rsp_valid,
   output sv39ptm_pkg::rsp_type          rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sv39ptm_pkg::PPN_W-1:0] csr_data
);

   sv39ptm_pkg::cmd_type   cmd;
   sv39ptm_pkg::flags_type flags;

   assign csr_ready = 1'b1;

   sv39ptm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .flags     (flags)
   );

   sv39ptm_dp #(
      .TABLE_PAGES   (TABLE_PAGES),
      .MAX_RUN_PAGES (MAX_RUN_PAGES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .flags     (flags),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/sv39_page_table_mapper_tb.sv
`timescale 1ns / 1ps

module sv39_page_table_mapper_tb;
   import sv39ptm_pkg::*;

   localparam int TABLE_PAGES   = 64;
   localparam int MAX_RUN_PAGES = 4096;
   localparam int STORE_ENTRIES = TABLE_PAGES * ENTRIES;
   localparam int N_PLAN        = 22;
   localparam int PHASE_ITEMS   = 25;
   localparam longint LIMIT     = 64'd8_000_000;

   localparam logic [PPN_W-1:0] PPN_ALL = '1;
   localparam rsp_type IDLE_RSP = '{read_data: '0, pages_mapped: '0,
                                    tables_in_use: 7'd1, status: STATUS_OK};
   // level-2 indices that the directed part leaves populated
   localparam logic [9*9-1:0] HOT_VPN2 = {9'd0, 9'h1ff, 9'd5, 9'd6, 9'd7,
                                          9'd8, 9'd9, 9'd10, 9'd11};

   typedef struct packed {
      logic             retarget;
      logic [PPN_W-1:0] base;
      req_type          req;
      logic             typed;
      rsp_type          rsp;
   } plan_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   req_type          req_data  = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [PPN_W-1:0] csr_data  = '0;

   bit [ENTRY_W-1:0] shadow_tables [0:STORE_ENTRIES-1];
   int unsigned      shadow_next_slot = 1;
   logic [PPN_W-1:0] shadow_base      = '0;
   rsp_type          results_due [$];
   rsp_type          oldest;
   bit               failed = 1'b0;
   longint           cycles = 0;

   sv39_page_table_mapper #(
      .TABLE_PAGES   (TABLE_PAGES),
      .MAX_RUN_PAGES (MAX_RUN_PAGES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   function automatic req_type map_req(input logic [VPAGE_W-1:0] vp,
                                       input logic [PPN_W-1:0] pp,
                                       input logic [PERM_W-1:0] perm,
                                       input logic [COUNT_W-1:0] count);
      req_type r;
      r = '0;
      r.op         = OP_MAP;
      r.virt_page  = vp;
      r.phys_page  = pp;
      r.perm_bits  = perm;
      r.page_count = count;
      return r;
   endfunction

   function automatic req_type read_req(input logic [RADDR_W-1:0] addr);
      req_type r;
      r = '0;
      r.op           = OP_READ;
      r.read_address = addr;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // follow one table entry to its child slot, allocating a table when it is empty
   function automatic status_type resolve_level(input int unsigned parent,
                                                input logic [IDX_W-1:0] idx,
                                                output int unsigned child);
      int unsigned      at;
      logic [PPN_W-1:0] ppn;
      logic [PPN_W-1:0] rel;
      at = parent * ENTRIES + idx;
      child = 0;
      if (!shadow_tables[at][PTE_V_BIT]) begin
         if (shadow_next_slot >= TABLE_PAGES) return STATUS_NO_TABLE;
         child = shadow_next_slot;
         shadow_next_slot++;
         ppn = shadow_base + child;
         shadow_tables[at] = {10'd0, ppn, 10'd1};
         return STATUS_OK;
      end
      ppn = shadow_tables[at][PTE_PPN_LSB +: PPN_W];
      rel = ppn - shadow_base;
      if (rel >= TABLE_PAGES) return STATUS_BAD_PTR;
      child = 32'(rel);
      return STATUS_OK;
   endfunction

   function automatic rsp_type map_pages(input req_type r);
      rsp_type          res;
      logic [VPAGE_W-1:0] vp;
      logic [PPN_W-1:0] pp;
      int unsigned      count;
      int unsigned      mid;
      int unsigned      leaf;
      status_type       st;
      res = '0;
      st = STATUS_OK;
      if (r.op == OP_READ) begin
         if (r.read_address < STORE_ENTRIES) res.read_data = shadow_tables[r.read_address];
         else st = STATUS_BAD_PTR;
      end else begin
         vp = r.virt_page;
         pp = r.phys_page;
         count = 32'(r.page_count);
         if (count > MAX_RUN_PAGES) count = MAX_RUN_PAGES;
         for (int unsigned i = 0; i < count; i++) begin
            st = resolve_level(0, vp[VPN2_LSB +: IDX_W], mid);
            if (st != STATUS_OK) break;
            st = resolve_level(mid, vp[VPN1_LSB +: IDX_W], leaf);
            if (st != STATUS_OK) break;
            shadow_tables[leaf * ENTRIES + vp[IDX_W-1:0]] = {10'd0, pp, r.perm_bits};
            res.pages_mapped++;
            vp++;
            pp++;
         end
      end
      res.tables_in_use = shadow_next_slot[TUSE_W-1:0];
      res.status = st;
      return res;
   endfunction

   // leaves start high on return; the caller raises it again or drops it in the same step
   task automatic send(input req_type r, input bit use_typed, input rsp_type typed);
      int      gap;
      rsp_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = map_pages(r);
      results_due.push_back(use_typed ? typed : predicted);
   endtask

   task automatic drain_results();
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_table_base(input logic [PPN_W-1:0] value);
      int gap;
      gap = pick_gap();
      repeat (gap) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      shadow_base = value;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (results_due.size() == 0) begin
            $display("%0t ns: response with none expected, got %h", $time, rsp_data);
            failed = 1'b1;
         end else begin
            oldest = results_due.pop_front();
            if (rsp_data.read_data !== oldest.read_data) begin
               $display("%0t ns: read_data expected %h got %h", $time,
                        oldest.read_data, rsp_data.read_data);
               failed = 1'b1;
            end
            if (rsp_data.pages_mapped !== oldest.pages_mapped) begin
               $display("%0t ns: pages_mapped expected %0d got %0d", $time,
                        oldest.pages_mapped, rsp_data.pages_mapped);
               failed = 1'b1;
            end
            if (rsp_data.tables_in_use !== oldest.tables_in_use) begin
               $display("%0t ns: tables_in_use expected %0d got %0d", $time,
                        oldest.tables_in_use, rsp_data.tables_in_use);
               failed = 1'b1;
            end
            if (rsp_data.status !== oldest.status) begin
               $display("%0t ns: status expected %0d got %0d", $time,
                        oldest.status, rsp_data.status);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("sv39_page_table_mapper regression: fail");
         $finish;
      end
   end

   initial begin
      plan_row_type       plan [0:N_PLAN-1];
      req_type            r;
      logic [PPN_W-1:0]   next_base;
      int                 roll;
      int                 size_roll;

      plan[0]  = '{1'b1, PPN_ALL, read_req(15'd0), 1'b1, IDLE_RSP};
      plan[1]  = '{1'b0, '0, read_req(15'h7fff), 1'b1, IDLE_RSP};
      plan[2]  = '{1'b0, '0, map_req(27'h7ffffff, PPN_ALL, 10'h3ff, 13'd0), 1'b1, IDLE_RSP};
      plan[3]  = '{1'b0, '0, map_req(27'd0, 44'd0, 10'd0, 13'd1), 1'b0, '0};
      plan[4]  = '{1'b0, '0, read_req(15'd0), 1'b0, '0};
      plan[5]  = '{1'b0, '0, map_req(27'h7ffffff, PPN_ALL, 10'h3ff, 13'd3), 1'b0, '0};
      plan[6]  = '{1'b0, '0, read_req({6'd4, 9'h1ff}), 1'b0, '0};
      plan[7]  = '{1'b0, '0, map_req({9'd5, 18'd0}, 44'h123_4567_89ab, 10'h0cf, 13'h1fff),
                   1'b0, '0};
      plan[8]  = '{1'b0, '0, map_req({9'd6, 18'd0}, 44'h0ff_0000_0000, 10'h001, 13'd4096),
                   1'b0, '0};
      plan[9]  = '{1'b0, '0, map_req({9'd7, 18'd0}, 44'h800_0000_0000, 10'h0c7, 13'd4096),
                   1'b0, '0};
      plan[10] = '{1'b0, '0, map_req({9'd8, 18'd0}, 44'hfff_ffff_f800, 10'h2aa, 13'd4096),
                   1'b0, '0};
      plan[11] = '{1'b0, '0, map_req({9'd9, 18'd0}, 44'h000_0001_0000, 10'h155, 13'd4096),
                   1'b0, '0};
      plan[12] = '{1'b0, '0, map_req({9'd10, 18'd0}, 44'h5a5_a5a5_a5a5, 10'h3c3, 13'd4096),
                   1'b0, '0};
      plan[13] = '{1'b0, '0, map_req({9'd11, 18'd0}, 44'h3c3_c3c3_c3c3, 10'h00f, 13'd4096),
                   1'b0, '0};
      plan[14] = '{1'b0, '0, map_req({9'd20, 18'd0}, 44'h000_0000_1000, 10'h0ff, 13'd1),
                   1'b0, '0};
      plan[15] = '{1'b0, '0, map_req({9'd5, 9'd2, 9'd7}, 44'h00a_bcde_f012, 10'h0db, 13'd100),
                   1'b0, '0};
      plan[16] = '{1'b0, '0, read_req({6'd63, 9'd0}), 1'b0, '0};
      plan[17] = '{1'b1, '0, map_req({9'd5, 18'd0}, 44'h000_0000_0042, 10'h0f1, 13'd2),
                   1'b0, '0};
      plan[18] = '{1'b1, 44'h800, map_req({9'd6, 18'd5}, 44'h111_2222_3333, 10'h0a5, 13'd4),
                   1'b0, '0};
      plan[19] = '{1'b0, '0, read_req({6'd1, 9'd5}), 1'b0, '0};
      plan[20] = '{1'b1, PPN_ALL, map_req({9'd7, 9'd1, 9'd0}, 44'h777_7777_7777, 10'h1e1,
                   13'd10), 1'b0, '0};
      plan[21] = '{1'b0, '0, read_req({6'd0, 9'd7}), 1'b0, '0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < N_PLAN; k++) begin
         if (plan[k].retarget) begin
            start <= 1'b0;
            drain_results();
            write_table_base(plan[k].base);
         end
         send(plan[k].req, plan[k].typed, plan[k].rsp);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       next_base = '0;
            1:       next_base = {12'($urandom), 32'($urandom)};
            2:       next_base = PPN_ALL;
            default: next_base = PPN_W'($urandom_range(1, 63));
         endcase
         start <= 1'b0;
         drain_results();
         write_table_base(next_base);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            r.op           = OP_MAP;
            r.virt_page    = VPAGE_W'($urandom);
            r.phys_page    = {12'($urandom), 32'($urandom)};
            r.perm_bits    = PERM_W'($urandom);
            r.page_count   = COUNT_W'($urandom_range(0, 40));
            r.read_address = RADDR_W'($urandom);
            if (roll < 30) begin
               r.op = OP_READ;
               if ($urandom_range(0, 1) == 0)
                  r.read_address = {6'($urandom_range(0, 63)), 9'($urandom_range(0, 15))};
            end else begin
               // mostly land in populated regions so walks get past the root
               if (roll < 85)
                  r.virt_page = {HOT_VPN2[9 * $urandom_range(0, 8) +: 9],
                                 9'($urandom_range(0, 7)), 9'($urandom)};
               size_roll = $urandom_range(0, 49);
               if (size_roll == 0) r.page_count = COUNT_W'($urandom);
               else if (size_roll < 4) r.page_count = COUNT_W'($urandom_range(100, 1200));
            end
            send(r, 1'b0, IDLE_RSP);
         end
      end

      start <= 1'b0;
      drain_results();
      repeat (40) @(posedge clock);
      if (!failed)
         $display("sv39_page_table_mapper regression: pass");
      else
         $display("sv39_page_table_mapper regression: fail");
      $finish;
   end

endmodule
